// ===== src/prq_pkg.sv =====
// Package for the priority ready queue: sizes, command codes, cell types.
// Used by the interfaces, the queue cell and the top level.
package prq_pkg;

  localparam int QUEUE_DEPTH = 64;
  localparam int ID_BITS     = 8;
  localparam int PRI_BITS    = 6;
  localparam int CNT_BITS    = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_POP    = 2'd1,
    CMD_YIELD  = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_e;

  // What the cell row does this cycle.
  typedef enum logic [1:0] {
    OP_HOLD,
    OP_INSERT,
    OP_POP,
    OP_INS_POP
  } op_e;

  typedef struct packed {
    logic [ID_BITS-1:0]  id;
    logic [PRI_BITS-1:0] pri;
  } entry_t;

  typedef struct packed {
    op_e    op;
    entry_t ent;
  } cell_ctrl_t;

endpackage

// ===== src/prq_if.sv =====
// Channel interfaces of the priority ready queue: command, result, config.
// Depends on prq_pkg.
interface prq_in_if;
  import prq_pkg::*;
  logic                valid;
  logic                ready;
  logic [1:0]          cmd;
  logic [ID_BITS-1:0]  thread_id;
  logic [PRI_BITS-1:0] priority_req;
  modport source (output valid, cmd, thread_id, priority_req, input ready);
  modport sink   (input valid, cmd, thread_id, priority_req, output ready);
endinterface

interface prq_out_if;
  import prq_pkg::*;
  logic                valid;
  logic                ready;
  logic [ID_BITS-1:0]  next_id;
  logic [PRI_BITS-1:0] next_priority;
  logic                from_queue;
  logic                overflow;
  logic [CNT_BITS-1:0] occupancy;
  modport source (output valid, next_id, next_priority, from_queue, overflow, occupancy,
                  input ready);
  modport sink   (input valid, next_id, next_priority, from_queue, overflow, occupancy,
                  output ready);
endinterface

interface prq_cfg_if;
  import prq_pkg::*;
  logic               valid;
  logic               ready;
  logic [ID_BITS-1:0] idle_id;
  modport source (output valid, idle_id, input ready);
  modport sink   (input valid, idle_id, output ready);
endinterface

// ===== src/prq_cell.sv =====
// One slot of the sorted shift-register queue: holds an entry and trades
// with its neighbors on insert, pop and insert-then-pop. Depends on prq_pkg.
module prq_cell (
  input  logic                clk_i,
  input  prq_pkg::cell_ctrl_t ctl_i,
  input  logic                live_i,      // slot holds a queued entry
  input  logic                prev_c_i,    // slot above is at or past the insert point
  input  prq_pkg::entry_t     prev_q_i,
  input  prq_pkg::entry_t     next_q_i,
  input  prq_pkg::entry_t     next_ins_i,  // what the slot below holds after insert
  output prq_pkg::entry_t     q_o,
  output logic                c_o,
  output prq_pkg::entry_t     ins_o
);
  import prq_pkg::*;

  entry_t ent_q, ent_d;

  // Ties go behind: the new entry lands before the first lower priority.
  assign c_o   = !live_i || (ent_q.pri < ctl_i.ent.pri);
  assign ins_o = prev_c_i ? prev_q_i : (c_o ? ctl_i.ent : ent_q);
  assign q_o   = ent_q;

  always_comb begin
    case (ctl_i.op)
      OP_INSERT:  ent_d = ins_o;
      OP_POP:     ent_d = next_q_i;
      OP_INS_POP: ent_d = next_ins_i;
      default:    ent_d = ent_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    ent_q <= ent_d;
  end

endmodule

// ===== src/priority_ready_queue.sv =====
// Priority ready queue: a sorted row of shift cells plus result register.
// Depends on prq_pkg, prq_if and prq_cell.
//
// The queue takes one command per clock cycle and shows its result in the
// cycle after the command beat, held in an output register; a new command
// is taken whenever that register is empty or its beat is taken in the same
// cycle. Every slot of the row compares its own priority with the incoming
// one and trades entries only with its direct neighbors, so insert, pop and
// yield (insert then pop) each finish within the cycle of the beat. No
// clearing pass runs after reset: the entry count marks which slots hold
// data. The idle id register may be written whenever the queue is idle.
module priority_ready_queue (
  input  logic         clk_i,
  input  logic         rst_ni,
  prq_in_if.sink       in_i,
  prq_out_if.source    out_o,
  prq_cfg_if.sink      cfg_i
);
  import prq_pkg::*;

  logic [CNT_BITS-1:0] count_q, count_d;
  logic [ID_BITS-1:0]  idle_q;
  logic                out_valid_q;
  logic [ID_BITS-1:0]  res_id_q, res_id_d;
  logic [PRI_BITS-1:0] res_pri_q, res_pri_d;
  logic                res_fq_q, res_fq_d;
  logic                res_ovf_q, res_ovf_d;

  logic       accept, full, empty;
  op_e        op;
  cell_ctrl_t ctl;

  entry_t cell_q   [QUEUE_DEPTH];
  entry_t cell_ins [QUEUE_DEPTH];
  logic   cell_c   [QUEUE_DEPTH];
  logic   live     [QUEUE_DEPTH];

  assign in_i.ready  = !out_valid_q || out_o.ready;
  assign accept      = in_i.valid && in_i.ready;
  assign cfg_i.ready = 1'b1;

  assign full  = (count_q == CNT_BITS'(QUEUE_DEPTH));
  assign empty = (count_q == '0);

  always_comb begin
    op        = OP_HOLD;
    count_d   = count_q;
    res_id_d  = '0;
    res_pri_d = '0;
    res_fq_d  = 1'b0;
    res_ovf_d = 1'b0;
    case (cmd_e'(in_i.cmd))
      CMD_INSERT: begin
        if (full) begin
          res_ovf_d = 1'b1;
        end else begin
          op      = OP_INSERT;
          count_d = count_q + 1'b1;
        end
      end
      CMD_POP, CMD_YIELD: begin
        if (cmd_e'(in_i.cmd) == CMD_YIELD && in_i.thread_id != idle_q && !full) begin
          // Insert and pop at once: the head comes out of the inserted row.
          op        = OP_INS_POP;
          res_id_d  = cell_ins[0].id;
          res_pri_d = cell_ins[0].pri;
          res_fq_d  = 1'b1;
        end else begin
          res_ovf_d = (cmd_e'(in_i.cmd) == CMD_YIELD) && (in_i.thread_id != idle_q);
          if (empty) begin
            res_id_d = idle_q;
          end else begin
            op        = OP_POP;
            res_id_d  = cell_q[0].id;
            res_pri_d = cell_q[0].pri;
            res_fq_d  = 1'b1;
            count_d   = count_q - 1'b1;
          end
        end
      end
      default: begin
        op = OP_HOLD;
      end
    endcase
  end

  assign ctl.op      = accept ? op : OP_HOLD;
  assign ctl.ent.id  = in_i.thread_id;
  assign ctl.ent.pri = in_i.priority_req;

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    assign live[i] = (count_q > CNT_BITS'(i));
    if (i == 0) begin : g_head
      prq_cell u_cell (
        .clk_i      (clk_i),
        .ctl_i      (ctl),
        .live_i     (live[i]),
        .prev_c_i   (1'b0),
        .prev_q_i   ('0),
        .next_q_i   (cell_q[i+1]),
        .next_ins_i (cell_ins[i+1]),
        .q_o        (cell_q[i]),
        .c_o        (cell_c[i]),
        .ins_o      (cell_ins[i])
      );
    end else if (i == QUEUE_DEPTH - 1) begin : g_tail
      prq_cell u_cell (
        .clk_i      (clk_i),
        .ctl_i      (ctl),
        .live_i     (live[i]),
        .prev_c_i   (cell_c[i-1]),
        .prev_q_i   (cell_q[i-1]),
        .next_q_i   ('0),
        .next_ins_i ('0),
        .q_o        (cell_q[i]),
        .c_o        (cell_c[i]),
        .ins_o      (cell_ins[i])
      );
    end else begin : g_mid
      prq_cell u_cell (
        .clk_i      (clk_i),
        .ctl_i      (ctl),
        .live_i     (live[i]),
        .prev_c_i   (cell_c[i-1]),
        .prev_q_i   (cell_q[i-1]),
        .next_q_i   (cell_q[i+1]),
        .next_ins_i (cell_ins[i+1]),
        .q_o        (cell_q[i]),
        .c_o        (cell_c[i]),
        .ins_o      (cell_ins[i])
      );
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      idle_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        count_q <= count_d;
      end
      if (cfg_i.valid) begin
        idle_q <= cfg_i.idle_id;
      end
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_id_q  <= res_id_d;
      res_pri_q <= res_pri_d;
      res_fq_q  <= res_fq_d;
      res_ovf_q <= res_ovf_d;
    end
  end

  // Occupancy after the command is the live count once the beat is taken.
  logic [CNT_BITS-1:0] occ_q;
  always_ff @(posedge clk_i) begin
    if (accept) begin
      occ_q <= count_d;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.next_id       = res_id_q;
  assign out_o.next_priority = res_pri_q;
  assign out_o.from_queue    = res_fq_q;
  assign out_o.overflow      = res_ovf_q;
  assign out_o.occupancy     = occ_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_BITS'(QUEUE_DEPTH))
    else $error("entry count beyond queue depth");

  // A yield that overflows still pops, so one slot may be free afterwards.
  a_ovf_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && res_ovf_q |-> occ_q >= CNT_BITS'(QUEUE_DEPTH - 1))
    else $error("overflow flagged with room in the queue");

  a_head_sorted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    live[1] |-> cell_q[0].pri >= cell_q[1].pri)
    else $error("head outranked by second entry");

endmodule

// ===== tb/sv/prq_sched_checker.sv =====
`timescale 1ns / 1ps
// Scoreboard for the priority ready queue. It keeps its own sorted run list,
// predicts every result beat and compares it with what the queue returns.
// Depends on prq_pkg and prq_if.
module prq_sched_checker (
  input  logic clk_i,
  input  logic rst_ni,
  prq_in_if    cmd_ch,
  prq_out_if   pick_ch,
  prq_cfg_if   cfg_ch,
  output int   mismatches_o,
  output int   picks_owed_o
);
  import prq_pkg::*;

  typedef struct packed {
    logic [ID_BITS-1:0]  id;
    logic [PRI_BITS-1:0] pri;
    logic                from_queue;
    logic                overflow;
    logic [CNT_BITS-1:0] occupancy;
  } pick_t;

  entry_t             run_list [QUEUE_DEPTH];
  int                 run_cnt;
  logic [ID_BITS-1:0] idle_tid;
  pick_t              picks_due [$];
  int                 mismatches;

  // Goes behind every entry of greater or equal priority.
  function automatic logic enlist(entry_t ent);
    int slot;
    if (run_cnt >= QUEUE_DEPTH) return 1'b0;
    slot = run_cnt;
    while (slot > 0 && run_list[slot-1].pri < ent.pri) begin
      run_list[slot] = run_list[slot-1];
      slot--;
    end
    run_list[slot] = ent;
    run_cnt++;
    return 1'b1;
  endfunction

  function automatic pick_t take_head();
    pick_t p;
    p = '0;
    if (run_cnt == 0) begin
      p.id = idle_tid;
    end else begin
      p.id         = run_list[0].id;
      p.pri        = run_list[0].pri;
      p.from_queue = 1'b1;
      for (int i = 1; i < run_cnt; i++) run_list[i-1] = run_list[i];
      run_cnt--;
    end
    return p;
  endfunction

  function automatic pick_t schedule(cmd_e op, entry_t ent);
    pick_t p;
    logic  dropped;
    p       = '0;
    dropped = 1'b0;
    case (op)
      CMD_INSERT: dropped = !enlist(ent);
      CMD_POP:    p = take_head();
      CMD_YIELD: begin
        // a yield by the idle thread does not put it on the list, it is then a plain pop
        if (ent.id != idle_tid) dropped = !enlist(ent);
        p = take_head();
      end
      default: ;
    endcase
    p.overflow  = dropped;
    p.occupancy = CNT_BITS'(run_cnt);
    return p;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    pick_t got;
    pick_t want;
    if (!rst_ni) begin
      run_cnt  = 0;
      idle_tid = '0;
      picks_due.delete();
    end else begin
      // result beats first: a same-edge command beat cannot be its source
      if (pick_ch.valid && pick_ch.ready) begin
        got = {pick_ch.next_id, pick_ch.next_priority, pick_ch.from_queue,
               pick_ch.overflow, pick_ch.occupancy};
        if (picks_due.size() == 0) begin
          mismatches++;
          $display("%0t: result beat with none expected: id=%0d pri=%0d",
                   $time, got.id, got.pri,
                   " from_queue=%0b overflow=%0b occupancy=%0d",
                   got.from_queue, got.overflow, got.occupancy);
        end else begin
          want = picks_due.pop_front();
          if (got !== want) begin
            mismatches++;
            $display("%0t: result mismatch: expected id=%0d pri=%0d", $time,
                     want.id, want.pri,
                     " from_queue=%0b overflow=%0b occupancy=%0d",
                     want.from_queue, want.overflow, want.occupancy,
                     "; got id=%0d pri=%0d", got.id, got.pri,
                     " from_queue=%0b overflow=%0b occupancy=%0d",
                     got.from_queue, got.overflow, got.occupancy);
          end
        end
      end
      if (cfg_ch.valid && cfg_ch.ready) idle_tid = cfg_ch.idle_id;
      if (cmd_ch.valid && cmd_ch.ready)
        picks_due.push_back(schedule(cmd_e'(cmd_ch.cmd),
                                     {cmd_ch.thread_id, cmd_ch.priority_req}));
    end
    mismatches_o <= mismatches;
    picks_owed_o <= picks_due.size();
  end

endmodule

// ===== tb/sv/tb_priority_ready_queue.sv =====
`timescale 1ns / 1ps
// Testbench top for the priority ready queue: clock, reset, command and
// idle id stimulus, receiver stalls, watchdog and verdict.
// Depends on prq_pkg, prq_if, prq_sched_checker and the queue RTL.
module tb_priority_ready_queue;
  import prq_pkg::*;

  localparam int QUIET_LIMIT = 3000;
  localparam int SINK_HOLD   = 400;
  localparam int DRAIN_WAIT  = 20;

  logic               clk_i        = 1'b0;
  logic               rst_ni       = 1'b0;
  logic               sink_held    = 1'b0;
  int                 tx_idle_pct  = 0;
  int                 rx_stall_pct = 0;
  int                 quiet_cycles = 0;
  logic [ID_BITS-1:0] idle_now     = '0;
  int                 mismatches;
  int                 picks_owed;

  prq_in_if  cmd_ch ();
  prq_out_if pick_ch ();
  prq_cfg_if cfg_ch ();

  priority_ready_queue dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (cmd_ch),
    .out_o  (pick_ch),
    .cfg_i  (cfg_ch)
  );

  prq_sched_checker chk (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_ch       (cmd_ch),
    .pick_ch      (pick_ch),
    .cfg_ch       (cfg_ch),
    .mismatches_o (mismatches),
    .picks_owed_o (picks_owed)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    pick_ch.ready <= rst_ni && !sink_held && ($urandom_range(99) >= rx_stall_pct);
  end

  // Ends the run after a long stretch with no beat on any channel.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((cmd_ch.valid && cmd_ch.ready) || (pick_ch.valid && pick_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= QUIET_LIMIT) begin
        $display("tb_priority_ready_queue NOT OK");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  task automatic send_cmd(cmd_e op, logic [ID_BITS-1:0] tid, logic [PRI_BITS-1:0] pri);
    while ($urandom_range(99) < tx_idle_pct) begin
      cmd_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    cmd_ch.valid        <= 1'b1;
    cmd_ch.cmd          <= op;
    cmd_ch.thread_id    <= tid;
    cmd_ch.priority_req <= pri;
    do @(posedge clk_i); while (!cmd_ch.ready);
  endtask

  // Only while idle: every expected beat back, then a few spare cycles.
  task automatic set_idle(logic [ID_BITS-1:0] tid);
    cmd_ch.valid <= 1'b0;
    do @(posedge clk_i); while (picks_owed != 0);
    repeat (4) @(posedge clk_i);
    cfg_ch.valid   <= 1'b1;
    cfg_ch.idle_id <= tid;
    do @(posedge clk_i); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    idle_now = tid;
  endtask

  task automatic send_random(int ins_pct, int pop_pct);
    int                  roll;
    cmd_e                op;
    logic [ID_BITS-1:0]  tid;
    logic [PRI_BITS-1:0] pri;
    roll = $urandom_range(99);
    if (roll < ins_pct) op = CMD_INSERT;
    else if (roll < ins_pct + pop_pct) op = CMD_POP;
    else if (roll < 97) op = CMD_YIELD;
    else op = CMD_NONE;
    tid = ($urandom_range(7) == 0) ? idle_now : ID_BITS'($urandom);
    case ($urandom_range(3))
      0: pri = PRI_BITS'($urandom);
      1: pri = PRI_BITS'($urandom_range(3));  // many ties, checks FIFO order
      2: pri = $urandom_range(1) ? {PRI_BITS{1'b1}} : {PRI_BITS{1'b0}};
      default: pri = PRI_BITS'($urandom_range(44, 40));
    endcase
    send_cmd(op, tid, pri);
  endtask

  // fill past full, churn, then drain
  task automatic run_phase();
    repeat (75) send_random(95, 2);
    repeat (25) send_random(35, 35);
    repeat (50) send_random(5, 90);
  endtask

  task automatic hold_sink(int cycles);
    sink_held <= 1'b1;
    repeat (cycles) @(posedge clk_i);
    sink_held <= 1'b0;
  endtask

  initial begin
    cmd_ch.valid        <= 1'b0;
    cmd_ch.cmd          <= CMD_INSERT;
    cmd_ch.thread_id    <= '0;
    cmd_ch.priority_req <= '0;
    cfg_ch.valid        <= 1'b0;
    cfg_ch.idle_id      <= '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    set_idle(8'hFF);
    send_cmd(CMD_POP,    8'd0,   6'd0);   // empty: idle id comes back
    send_cmd(CMD_YIELD,  8'hFF,  6'd5);   // idle thread yields on empty list
    send_cmd(CMD_NONE,   8'd0,   6'd0);
    send_cmd(CMD_INSERT, 8'd0,   6'd0);
    send_cmd(CMD_INSERT, 8'hFF,  6'd63);  // plain insert of the idle id is kept
    send_cmd(CMD_INSERT, 8'd1,   6'd63);
    send_cmd(CMD_INSERT, 8'd2,   6'd0);
    send_cmd(CMD_INSERT, 8'hAA,  6'h2A);
    send_cmd(CMD_INSERT, 8'h55,  6'h15);
    send_cmd(CMD_NONE,   8'hC3,  6'h3C);
    send_cmd(CMD_YIELD,  8'd3,   6'd63);
    send_cmd(CMD_YIELD,  8'hFF,  6'd63);
    repeat (6) send_cmd(CMD_POP, 8'd0, 6'd0);
    send_cmd(CMD_YIELD,  8'd7,   6'd10);  // goes in and straight back out

    // sink held off early so the queue output backs up into the input
    set_idle(8'h00);
    fork
      hold_sink(SINK_HOLD);
      run_phase();
    join

    tx_idle_pct <= 45;
    set_idle(ID_BITS'($urandom));
    run_phase();

    tx_idle_pct  <= 0;
    rx_stall_pct <= 45;
    set_idle(8'h01);
    run_phase();

    tx_idle_pct  <= 34;
    rx_stall_pct <= 34;
    set_idle(ID_BITS'($urandom));
    run_phase();

    cmd_ch.valid <= 1'b0;
    do @(posedge clk_i); while (picks_owed != 0);
    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (mismatches == 0 && picks_owed == 0)
      $display("tb_priority_ready_queue OK");
    else
      $display("tb_priority_ready_queue NOT OK");
    $finish;
  end

endmodule

// ===== filelist.f =====
src/prq_pkg.sv
src/prq_if.sv
src/prq_cell.sv
src/priority_ready_queue.sv
tb/sv/prq_sched_checker.sv
tb/sv/tb_priority_ready_queue.sv
